[sv/fso_pkg.sv]
// ----------------------------------------------------------------------------
// fso_pkg - shared types, codes and colour helpers
// Register indexes, colour mode codes, the pixel request and palette write
// structs, and the direct colour expansion used by the scan-out block.
// ----------------------------------------------------------------------------
`default_nettype none

package fso_pkg;

  localparam int PALETTE_ENTRIES  = 256;
  localparam int PAL_AW           = 8;
  localparam int DEF_MAX_WIDTH    = 1024;
  localparam int DEF_MAX_LINE_WDS = 1024;

  // register indexes
  localparam logic [1:0] REG_PIX_MODE   = 2'd0;
  localparam logic [1:0] REG_LINE_WIDTH = 2'd1;
  localparam logic [1:0] REG_LINE_WORDS = 2'd2;

  // colour modes; codes 6 and 7 fall back to 8-bit indexed
  localparam logic [2:0] MODE_IDX8     = 3'd0;
  localparam logic [2:0] MODE_IDX4     = 3'd1;
  localparam logic [2:0] MODE_IDX2     = 3'd2;
  localparam logic [2:0] MODE_RGB565   = 3'd3;
  localparam logic [2:0] MODE_RGB555   = 3'd4;
  localparam logic [2:0] MODE_RGBA5551 = 3'd5;

  localparam logic [0:0] FUNC_PAL_WRITE = 1'b0;
  localparam logic [0:0] FUNC_FB_WORD   = 1'b1;

  localparam logic [31:0] OPAQUE_BLACK = 32'hFF00_0000;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0]  ALPHA_CLEAR  = 8'h00;

  typedef struct packed {
    logic [2:0]  mode;
    logic [10:0] width;       // already clamped to the maximum width
    logic [10:0] line_words;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  idx;
    logic        direct;
    logic        black;
    logic [15:0] word;
    logic [9:0]  x;
    logic        last;
    logic        line_end;
  } pix_req_t;

  typedef struct packed {
    logic                en;
    logic [PAL_AW-1:0]   addr;
    logic [23:0]         rgb;
  } pal_wr_t;

  function automatic logic [7:0] widen5(input logic [4:0] c);
    widen5 = {c, c[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] c);
    widen6 = {c, c[5:4]};
  endfunction

  function automatic logic is_direct(input logic [2:0] mode);
    is_direct = (mode == MODE_RGB565) || (mode == MODE_RGB555) ||
                (mode == MODE_RGBA5551);
  endfunction

  function automatic logic [31:0] direct_argb(input logic [2:0] mode,
                                              input logic [15:0] w);
    logic [31:0] c;
    c = OPAQUE_BLACK;
    unique case (mode)
      MODE_RGB565: c = {ALPHA_OPAQUE, widen5(w[15:11]), widen6(w[10:5]), widen5(w[4:0])};
      MODE_RGB555: c = {ALPHA_OPAQUE, widen5(w[14:10]), widen5(w[9:5]), widen5(w[4:0])};
      default:     c = {(w[0] ? ALPHA_OPAQUE : ALPHA_CLEAR),
                        widen5(w[15:11]), widen5(w[10:6]), widen5(w[5:1])};
    endcase
    direct_argb = c;
  endfunction

endpackage

`default_nettype wire

[sv/fso_in_if.sv]
// ----------------------------------------------------------------------------
// fso_in_if - input word channel
// Valid/ready channel carrying framebuffer words and palette writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface fso_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] word_data;
  logic [7:0]  palette_index;
  logic [23:0] palette_rgb;

  modport source (output valid, func, word_data, palette_index, palette_rgb,
                  input ready);
  modport sink   (input valid, func, word_data, palette_index, palette_rgb,
                  output ready);
  modport mon    (input valid, ready, func, word_data, palette_index, palette_rgb);
endinterface

`default_nettype wire

[sv/fso_out_if.sv]
// ----------------------------------------------------------------------------
// fso_out_if - output pixel channel
// Valid/ready channel carrying one ARGB8888 pixel per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface fso_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] argb;
  logic [9:0]  pixel_x;
  logic        last;
  logic        line_end;

  modport source (output valid, argb, pixel_x, last, line_end, input ready);
  modport sink   (input valid, argb, pixel_x, last, line_end, output ready);
  modport mon    (input valid, ready, argb, pixel_x, last, line_end);
endinterface

`default_nettype wire

[sv/fso_unpack.sv]
// ----------------------------------------------------------------------------
// fso_unpack - word unpacker and line position counter
// Takes input words, issues palette writes, and splits framebuffer words
// into pixel requests, one per cycle while the palette stage is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module fso_unpack #(
  parameter int MAX_LINE_WORDS = fso_pkg::DEF_MAX_LINE_WDS
) (
  input  wire                clk,
  input  wire                rst,
  input  fso_pkg::cfg_t      cfg,
  fso_in_if.sink             words,
  output logic               req_valid,
  input  wire                req_ready,
  output fso_pkg::pix_req_t  req,
  output fso_pkg::pal_wr_t   pal_wr
);
  import fso_pkg::*;

  localparam logic [12:0] WRAP_AT = 13'(MAX_LINE_WORDS);

  logic        busy;
  logic [15:0] sh;
  logic [10:0] cur_x;
  logic [3:0]  rem;
  logic [9:0]  word_pos;

  logic [3:0]  n_pix;
  logic [12:0] base;
  logic [12:0] width13;
  logic [12:0] avail;
  logic [3:0]  count;
  logic [12:0] pos_inc;
  logic [9:0]  word_pos_next;
  logic [7:0]  idx;
  logic [15:0] sh_next;
  logic        emit;
  logic        take;
  logic        fb_take;

  always_comb begin
    unique case (cfg.mode)
      MODE_IDX4: begin
        n_pix = 4'd4;
        base  = {1'b0, word_pos, 2'b00};
      end
      MODE_IDX2: begin
        n_pix = 4'd8;
        base  = {word_pos, 3'b000};
      end
      MODE_RGB565, MODE_RGB555, MODE_RGBA5551: begin
        n_pix = 4'd1;
        base  = {3'b000, word_pos};
      end
      default: begin
        n_pix = 4'd2;
        base  = {2'b00, word_pos, 1'b0};
      end
    endcase
  end

  // pixels of this word that fall inside the visible line
  always_comb begin
    width13 = {2'b00, cfg.width};
    avail   = width13 - base;
    if (base >= width13) begin
      count = 4'd0;
    end else if (avail < {9'd0, n_pix}) begin
      count = avail[3:0];
    end else begin
      count = n_pix;
    end
  end

  // advance the word counter, wrap at the stride or at MAX_LINE_WORDS
  always_comb begin
    pos_inc = {3'b000, word_pos} + 13'd1;
    if (pos_inc >= {2'b00, cfg.line_words} || pos_inc >= WRAP_AT) begin
      word_pos_next = 10'd0;
    end else begin
      word_pos_next = pos_inc[9:0];
    end
  end

  always_comb begin
    unique case (cfg.mode)
      MODE_IDX4: begin
        idx     = {4'h0, sh[3:0]};
        sh_next = {4'h0, sh[15:4]};
      end
      MODE_IDX2: begin
        idx     = {6'h00, sh[1:0]};
        sh_next = {2'b00, sh[15:2]};
      end
      default: begin
        idx     = sh[7:0];
        sh_next = {8'h00, sh[15:8]};
      end
    endcase
  end

  assign emit        = busy && req_ready;
  assign words.ready = !busy || (emit && rem == 4'd1);
  assign take        = words.valid && words.ready;
  assign fb_take     = take && (words.func == FUNC_FB_WORD);

  assign req_valid    = busy;
  assign req.idx      = idx;
  assign req.direct   = is_direct(cfg.mode);
  assign req.black    = (idx == 8'd0);
  assign req.word     = sh;
  assign req.x        = cur_x[9:0];
  assign req.last     = (rem == 4'd1);
  assign req.line_end = ({1'b0, cur_x} + 12'd1) == {1'b0, cfg.width};

  // palette writes land at once: every earlier read is already issued
  assign pal_wr.en   = take && (words.func == FUNC_PAL_WRITE);
  assign pal_wr.addr = words.palette_index;
  assign pal_wr.rgb  = words.palette_rgb;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      word_pos <= 10'd0;
    end else begin
      if (fb_take) begin
        word_pos <= word_pos_next;
      end
      if (fb_take && count != 4'd0) begin
        busy <= 1'b1;
      end else if (emit && rem == 4'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fb_take) begin
      sh    <= words.word_data;
      cur_x <= base[10:0];
      rem   <= count;
    end else if (emit) begin
      sh    <= sh_next;
      cur_x <= cur_x + 11'd1;
      rem   <= rem - 4'd1;
    end
  end

endmodule

`default_nettype wire

[sv/fso_palette.sv]
// ----------------------------------------------------------------------------
// fso_palette - palette memory, colour stage and output register
// Looks up indices in the palette RAM, builds ARGB8888 and holds the
// finished pixel until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module fso_palette (
  input  wire                clk,
  input  wire                rst,
  input  wire [2:0]          mode,
  input  wire                req_valid,
  output logic               req_ready,
  input  fso_pkg::pix_req_t  req,
  input  fso_pkg::pal_wr_t   pal_wr,
  fso_out_if.source          pixels
);
  import fso_pkg::*;

  logic [23:0]                mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] written;
  logic [23:0]                rd_data;
  logic                       rd_written;

  logic     s1_valid;
  pix_req_t s1;
  logic     s2_free;
  logic     s1_move;
  logic     rd_en;
  logic [31:0] colour;

  assign s2_free   = !pixels.valid || pixels.ready;
  assign s1_move   = s1_valid && s2_free;
  assign req_ready = !s1_valid || s1_move;
  assign rd_en     = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (pal_wr.en) begin
      mem[pal_wr.addr] <= pal_wr.rgb;
    end
    if (rd_en) begin
      rd_data <= mem[req.idx];
    end
  end

  // entries never written since reset read as opaque black
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (pal_wr.en) begin
      written[pal_wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_written <= written[req.idx];
      s1         <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rd_en) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_comb begin
    if (s1.direct) begin
      colour = direct_argb(mode, s1.word);
    end else if (s1.black || !rd_written) begin
      colour = OPAQUE_BLACK;
    end else begin
      colour = {ALPHA_OPAQUE, rd_data};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixels.valid <= 1'b0;
    end else if (s1_move) begin
      pixels.valid <= 1'b1;
    end else if (pixels.ready) begin
      pixels.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      pixels.argb     <= colour;
      pixels.pixel_x  <= s1.x;
      pixels.last     <= s1.last;
      pixels.line_end <= s1.line_end;
    end
  end

endmodule

`default_nettype wire

[sv/framebuffer_scanout_to_argb.sv]
// ----------------------------------------------------------------------------
// framebuffer_scanout_to_argb - framebuffer scan-out to ARGB8888
// words: one 16-bit framebuffer word of the current scan line (func 1) or a
// palette write (func 0, index and 24-bit colour) per word. pixels: one
// ARGB8888 pixel per word with its x position, last on the final pixel of a
// framebuffer word and line_end on the final visible pixel of the line.
// Indexed modes give 2, 4 or 8 pixels per framebuffer word, low bits first;
// the 16-bit modes give one. Drop pixels at or past line_width; a word in
// the padding gives none yet still advances the word counter.
// Throughput: one pixel per cycle while ready stays high, set by the single
// palette read port. A framebuffer word holds the unpacker until its last
// visible pixel (1 to 8) issues; a palette write or a fully dropped word
// never holds it. Path: a taken word passes the unpacker register, the
// palette read and then the output register.
// Reset: clear the word counter, the pipeline and the palette valid bits, so
// every entry reads as opaque black until written; no clearing pass. The
// registers return to 8-bit indexed, width 320 and a stride of 160 words.
// Stall: the output register holds while ready is low; the stages behind it
// fill and the words channel then drops ready.
// ----------------------------------------------------------------------------
`default_nettype none

module framebuffer_scanout_to_argb #(
  parameter int MAX_WIDTH      = fso_pkg::DEF_MAX_WIDTH,
  parameter int MAX_LINE_WORDS = fso_pkg::DEF_MAX_LINE_WDS
) (
  input  wire         clk,
  input  wire         rst,
  fso_in_if.sink      words,
  fso_out_if.source   pixels,
  input  wire         wr_en,
  input  wire  [1:0]  wr_index,
  input  wire  [10:0] wr_data
);
  import fso_pkg::*;

  localparam logic [12:0] WIDTH_LIMIT = 13'(MAX_WIDTH);

  logic [2:0]  pix_mode;
  logic [10:0] line_width;
  logic [10:0] line_words;

  cfg_t     cfg;
  pix_req_t req;
  pal_wr_t  pal_wr;
  logic     req_valid;
  logic     req_ready;

  // register file; the user must write it only while the block is idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_mode   <= MODE_IDX8;
      line_width <= 11'd320;
      line_words <= 11'd160;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_PIX_MODE:   pix_mode   <= wr_data[2:0];
        REG_LINE_WIDTH: line_width <= wr_data;
        REG_LINE_WORDS: line_words <= wr_data;
        default: ;
      endcase
    end
  end

  // clamp the visible width to the largest supported line
  always_comb begin
    cfg.mode       = pix_mode;
    cfg.line_words = line_words;
    if ({2'b00, line_width} > WIDTH_LIMIT) begin
      cfg.width = WIDTH_LIMIT[10:0];
    end else begin
      cfg.width = line_width;
    end
  end

  fso_unpack #(
    .MAX_LINE_WORDS(MAX_LINE_WORDS)
  ) u_unpack (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .words     (words),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .pal_wr    (pal_wr)
  );

  fso_palette u_palette (
    .clk       (clk),
    .rst       (rst),
    .mode      (pix_mode),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .pal_wr    (pal_wr),
    .pixels    (pixels)
  );

endmodule

`default_nettype wire

[sv/fso_checker.sv]
// ----------------------------------------------------------------------------
// fso_checker - port-level checks for the scan-out block
// Watches the pixel channel and flags reset, stall, flag and alpha slips.
// ----------------------------------------------------------------------------
`default_nettype none

module fso_checker (
  input wire        clk,
  input wire        rst,
  input wire        pix_valid,
  input wire        pix_ready,
  input wire [31:0] argb,
  input wire [9:0]  pixel_x,
  input wire        last,
  input wire        line_end
);

  // no pixel straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !pix_valid)
    else $error("pixel valid right after reset");

  // a stalled pixel stays put
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_ready |=>
      pix_valid && $stable(argb) && $stable(pixel_x) &&
      $stable(last) && $stable(line_end))
    else $error("stalled pixel changed");

  // nothing of a word survives past the end of the line
  a_line_end_last: assert property (@(posedge clk) disable iff (rst)
    pix_valid && line_end |-> last)
    else $error("line end without last");

  // alpha is only ever fully clear or fully opaque
  a_alpha: assert property (@(posedge clk) disable iff (rst)
    pix_valid |-> (argb[31:24] == 8'hFF || argb[31:24] == 8'h00))
    else $error("partial alpha");

endmodule

bind framebuffer_scanout_to_argb fso_checker u_fso_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_valid (pixels.valid),
  .pix_ready (pixels.ready),
  .argb      (pixels.argb),
  .pixel_x   (pixels.pixel_x),
  .last      (pixels.last),
  .line_end  (pixels.line_end)
);

`default_nettype wire
